>>> hw/rtl/ftcg_pkg.sv
// ----------------------------------------------------------------------------
// ftcg_pkg
// Shared types, widths and register codes of the floor texture coordinate
// generator.
// ----------------------------------------------------------------------------
package ftcg_pkg;

   localparam int MAX_SCREEN = 2048;
   localparam int FRAC_BITS  = 16;

   localparam int ROW_W      = 11;
   localparam int COL_W      = 11;
   localparam int POS_W      = 24;
   localparam int VEC_W      = 16;
   localparam int SCR_W      = 12;
   localparam int TEX_W      = 16;
   localparam int VEC_FRAC   = 14;
   localparam int CSR_DATA_W = 24;
   localparam int CSR_IDX_W  = 3;

   localparam int HALF_W = $clog2(MAX_SCREEN);
   localparam int DIST_W = HALF_W + FRAC_BITS;
   localparam int NUM_W  = VEC_W + COL_W + 1;
   localparam int QUO_W  = (NUM_W > DIST_W) ? NUM_W : DIST_W;
   localparam int RAY_W  = QUO_W + 2;
   localparam int PROD_W = VEC_FRAC + FRAC_BITS;
   localparam int DP_W   = VEC_W + 1;

   localparam logic [POS_W-1:0] RST_CAM_POS_X   = POS_W'(0);
   localparam logic [POS_W-1:0] RST_CAM_POS_Y   = POS_W'(0);
   localparam logic [VEC_W-1:0] RST_VIEW_DIR_X  = VEC_W'(16384);
   localparam logic [VEC_W-1:0] RST_VIEW_DIR_Y  = VEC_W'(0);
   localparam logic [VEC_W-1:0] RST_CAM_PLANE_X = VEC_W'(0);
   localparam logic [VEC_W-1:0] RST_CAM_PLANE_Y = VEC_W'(9830);
   localparam logic [SCR_W-1:0] RST_SCREEN_H    = SCR_W'(480);
   localparam logic [SCR_W-1:0] RST_SCREEN_W    = SCR_W'(640);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAM_POS_X   = 3'd0,
      CSR_CAM_POS_Y   = 3'd1,
      CSR_VIEW_DIR_X  = 3'd2,
      CSR_VIEW_DIR_Y  = 3'd3,
      CSR_CAM_PLANE_X = 3'd4,
      CSR_CAM_PLANE_Y = 3'd5,
      CSR_SCREEN_H    = 3'd6,
      CSR_SCREEN_W    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic        [POS_W-1:0] cam_pos_x;
      logic        [POS_W-1:0] cam_pos_y;
      logic signed [VEC_W-1:0] view_dir_x;
      logic signed [VEC_W-1:0] view_dir_y;
      logic signed [VEC_W-1:0] cam_plane_x;
      logic signed [VEC_W-1:0] cam_plane_y;
      logic        [SCR_W-1:0] screen_height;
      logic        [SCR_W-1:0] screen_width;
   } cfg_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] column;
   } req_type;

   typedef struct packed {
      logic [TEX_W-1:0] tex_u;
      logic [TEX_W-1:0] tex_v;
      logic             floor_row;
   } rsp_type;

endpackage

>>> hw/rtl/ftcg_csr.sv
// ----------------------------------------------------------------------------
// ftcg_csr
// Camera and screen configuration registers, written through a plain
// write port.
// ----------------------------------------------------------------------------
module ftcg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  ftcg_pkg::csr_index_type             csr_index,
   input  logic [ftcg_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   output ftcg_pkg::cfg_type                   cfg
);
   import ftcg_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cam_pos_x     <= RST_CAM_POS_X;
         cfg_ff.cam_pos_y     <= RST_CAM_POS_Y;
         cfg_ff.view_dir_x    <= signed'(RST_VIEW_DIR_X);
         cfg_ff.view_dir_y    <= signed'(RST_VIEW_DIR_Y);
         cfg_ff.cam_plane_x   <= signed'(RST_CAM_PLANE_X);
         cfg_ff.cam_plane_y   <= signed'(RST_CAM_PLANE_Y);
         cfg_ff.screen_height <= RST_SCREEN_H;
         cfg_ff.screen_width  <= RST_SCREEN_W;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CAM_POS_X:   cfg_ff.cam_pos_x     <= csr_wr_data[POS_W-1:0];
            CSR_CAM_POS_Y:   cfg_ff.cam_pos_y     <= csr_wr_data[POS_W-1:0];
            CSR_VIEW_DIR_X:  cfg_ff.view_dir_x    <= signed'(csr_wr_data[VEC_W-1:0]);
            CSR_VIEW_DIR_Y:  cfg_ff.view_dir_y    <= signed'(csr_wr_data[VEC_W-1:0]);
            CSR_CAM_PLANE_X: cfg_ff.cam_plane_x   <= signed'(csr_wr_data[VEC_W-1:0]);
            CSR_CAM_PLANE_Y: cfg_ff.cam_plane_y   <= signed'(csr_wr_data[VEC_W-1:0]);
            CSR_SCREEN_H:    cfg_ff.screen_height <= csr_wr_data[SCR_W-1:0];
            CSR_SCREEN_W:    cfg_ff.screen_width  <= csr_wr_data[SCR_W-1:0];
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/ftcg_div.sv
// ----------------------------------------------------------------------------
// ftcg_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module ftcg_div #(
   parameter int N_W = ftcg_pkg::QUO_W,
   parameter int D_W = ftcg_pkg::SCR_W
) (
   input  logic           clock,
   input  logic           advance,
   input  logic [N_W-1:0] num,
   input  logic [D_W-1:0] den,
   output logic [N_W-1:0] quo
);
   import ftcg_pkg::*;

   logic [D_W-1:0] rem_ff [N_W];
   logic [D_W-1:0] rem_in [N_W];
   logic [N_W-1:0] nq_ff  [N_W];
   logic [N_W-1:0] nq_in  [N_W];
   logic [D_W-1:0] den_ff [N_W];
   logic [D_W-1:0] den_in [N_W];

   for (genvar k = 0; k < N_W; k++) begin : g_stage
      logic [D_W-1:0] rem_prev;
      logic [N_W-1:0] nq_prev;
      logic [D_W-1:0] den_prev;
      logic [D_W:0]   trial;
      logic           ge;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign nq_prev  = num;
         assign den_prev = den;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign nq_prev  = nq_ff[k-1];
         assign den_prev = den_ff[k-1];
      end

      assign trial     = {rem_prev, nq_prev[N_W-1]};
      assign ge        = trial >= {1'b0, den_prev};
      assign rem_in[k] = ge ? D_W'(trial - {1'b0, den_prev}) : trial[D_W-1:0];
      assign nq_in[k]  = {nq_prev[N_W-2:0], ge};
      assign den_in[k] = den_prev;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         nq_ff  <= nq_in;
         den_ff <= den_in;
      end
   end

   assign quo = nq_ff[N_W-1];

endmodule

>>> hw/rtl/ftcg_out_fifo.sv
// ----------------------------------------------------------------------------
// ftcg_out_fifo
// Two-entry result buffer that parts the pipeline from the result channel.
// ----------------------------------------------------------------------------
module ftcg_out_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ftcg_pkg::rsp_type push_data,
   output logic              full,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ftcg_pkg::rsp_type rsp_data
);
   import ftcg_pkg::*;

   localparam logic [1:0] DEPTH = 2'd2;

   rsp_type    mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;

   assign pop       = rsp_valid && !rsp_stall;
   assign full      = count_ff == DEPTH;
   assign rsp_valid = count_ff != 2'd0;
   assign rsp_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= DEPTH)
      else $error("result buffer count out of range");
   assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("push into full result buffer");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff))
      else $error("result buffer pointers disagree with count");

endmodule

>>> hw/rtl/floor_texture_coord_gen.sv
// ----------------------------------------------------------------------------
// floor_texture_coord_gen: floor texture coordinates, one pixel per transfer
// A request passes stage 1, the divider, ray, multiply and add stages, then the result buffer.
// Throughput one pixel per cycle unless req_stall holds the pipeline; the 28-stage divider pipeline sets depth.
// Reset clears all valid bits and loads the default camera and screen.
// ----------------------------------------------------------------------------
module floor_texture_coord_gen (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ftcg_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ftcg_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  ftcg_pkg::csr_index_type             csr_index,
   input  logic [ftcg_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import ftcg_pkg::*;

   typedef struct packed {
      logic                   floor_row;
      logic                   neg_x;
      logic                   neg_y;
      logic signed [DP_W-1:0] dp_x;
      logic signed [DP_W-1:0] dp_y;
   } side_type;

   cfg_type cfg;
   logic    advance;
   logic    fifo_full;

   // stage 1: horizon, clamps and column products
   logic [SCR_W-1:0]  h_cl;
   logic [SCR_W-1:0]  w_cl;
   logic [HALF_W-1:0] half;
   logic [VEC_W-1:0]  mag_x;
   logic [VEC_W-1:0]  mag_y;

   logic              s1_valid_ff;
   logic [QUO_W-1:0]  s1_dnum_ff,  s1_dnum_in;
   logic [ROW_W-1:0]  s1_d_ff,     s1_d_in;
   logic [SCR_W-1:0]  s1_w_ff;
   logic [QUO_W-1:0]  s1_num_x_ff, s1_num_x_in;
   logic [QUO_W-1:0]  s1_num_y_ff, s1_num_y_in;
   side_type          s1_side_ff,  s1_side_in;

   always_comb begin
      h_cl = (cfg.screen_height > SCR_W'(MAX_SCREEN)) ? SCR_W'(MAX_SCREEN)
                                                      : cfg.screen_height;
      if (cfg.screen_width > SCR_W'(MAX_SCREEN)) begin
         w_cl = SCR_W'(MAX_SCREEN);
      end else if (cfg.screen_width == '0) begin
         w_cl = SCR_W'(1);
      end else begin
         w_cl = cfg.screen_width;
      end
      half  = HALF_W'(h_cl >> 1);
      mag_x = cfg.cam_plane_x[VEC_W-1] ? VEC_W'(-cfg.cam_plane_x) : VEC_W'(cfg.cam_plane_x);
      mag_y = cfg.cam_plane_y[VEC_W-1] ? VEC_W'(-cfg.cam_plane_y) : VEC_W'(cfg.cam_plane_y);

      s1_dnum_in  = QUO_W'({half, {FRAC_BITS{1'b0}}});
      s1_d_in     = ROW_W'(req_data.row - half);
      s1_num_x_in = QUO_W'({(NUM_W-1)'(mag_x) * (NUM_W-1)'(req_data.column), 1'b0});
      s1_num_y_in = QUO_W'({(NUM_W-1)'(mag_y) * (NUM_W-1)'(req_data.column), 1'b0});

      s1_side_in.floor_row = req_data.row > half;
      s1_side_in.neg_x     = cfg.cam_plane_x[VEC_W-1];
      s1_side_in.neg_y     = cfg.cam_plane_y[VEC_W-1];
      s1_side_in.dp_x      = DP_W'(cfg.view_dir_x) - DP_W'(cfg.cam_plane_x);
      s1_side_in.dp_y      = DP_W'(cfg.view_dir_y) - DP_W'(cfg.cam_plane_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_dnum_ff  <= s1_dnum_in;
         s1_d_ff     <= s1_d_in;
         s1_w_ff     <= w_cl;
         s1_num_x_ff <= s1_num_x_in;
         s1_num_y_ff <= s1_num_y_in;
         s1_side_ff  <= s1_side_in;
      end
   end

   // divider stages: distance and both column fractions
   logic [QUO_W-1:0] quo_d;
   logic [QUO_W-1:0] quo_x;
   logic [QUO_W-1:0] quo_y;

   ftcg_div #(.N_W(QUO_W), .D_W(ROW_W)) u_div_dist (
      .clock   (clock),
      .advance (advance),
      .num     (s1_dnum_ff),
      .den     (s1_d_ff),
      .quo     (quo_d)
   );

   ftcg_div #(.N_W(QUO_W), .D_W(SCR_W)) u_div_x (
      .clock   (clock),
      .advance (advance),
      .num     (s1_num_x_ff),
      .den     (s1_w_ff),
      .quo     (quo_x)
   );

   ftcg_div #(.N_W(QUO_W), .D_W(SCR_W)) u_div_y (
      .clock   (clock),
      .advance (advance),
      .num     (s1_num_y_ff),
      .den     (s1_w_ff),
      .quo     (quo_y)
   );

   logic     dv_valid_ff [QUO_W];
   side_type dv_side_ff  [QUO_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QUO_W; k++) begin
            dv_valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         dv_valid_ff[0] <= s1_valid_ff;
         for (int k = 1; k < QUO_W; k++) begin
            dv_valid_ff[k] <= dv_valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dv_side_ff[0] <= s1_side_ff;
         for (int k = 1; k < QUO_W; k++) begin
            dv_side_ff[k] <= dv_side_ff[k-1];
         end
      end
   end

   // ray stage: signed column fraction plus (dir - plane)
   side_type                dv_side;
   logic signed [RAY_W-1:0] qx_mag;
   logic signed [RAY_W-1:0] qy_mag;

   logic                    r_valid_ff;
   logic                    r_floor_ff;
   logic [DIST_W-1:0]       r_dist_ff;
   logic signed [RAY_W-1:0] r_ray_x_ff, r_ray_x_in;
   logic signed [RAY_W-1:0] r_ray_y_ff, r_ray_y_in;

   always_comb begin
      dv_side    = dv_side_ff[QUO_W-1];
      qx_mag     = RAY_W'(quo_x);
      qy_mag     = RAY_W'(quo_y);
      r_ray_x_in = (dv_side.neg_x ? -qx_mag : qx_mag) + RAY_W'(dv_side.dp_x);
      r_ray_y_in = (dv_side.neg_y ? -qy_mag : qy_mag) + RAY_W'(dv_side.dp_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else if (advance) begin
         r_valid_ff <= dv_valid_ff[QUO_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_floor_ff <= dv_side.floor_row;
         r_dist_ff  <= quo_d[DIST_W-1:0];
         r_ray_x_ff <= r_ray_x_in;
         r_ray_y_ff <= r_ray_y_in;
      end
   end

   // multiply stage: low bits of distance times ray
   logic [PROD_W-1:0] dist_ext;
   logic [PROD_W-1:0] ray_x_ext;
   logic [PROD_W-1:0] ray_y_ext;

   logic              m_valid_ff;
   logic              m_floor_ff;
   logic [PROD_W-1:0] m_prod_x_ff, m_prod_x_in;
   logic [PROD_W-1:0] m_prod_y_ff, m_prod_y_in;

   always_comb begin
      dist_ext    = PROD_W'(r_dist_ff);
      ray_x_ext   = PROD_W'(r_ray_x_ff);
      ray_y_ext   = PROD_W'(r_ray_y_ff);
      m_prod_x_in = dist_ext * ray_x_ext;
      m_prod_y_in = dist_ext * ray_y_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (advance) begin
         m_valid_ff <= r_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_floor_ff  <= r_floor_ff;
         m_prod_x_ff <= m_prod_x_in;
         m_prod_y_ff <= m_prod_y_in;
      end
   end

   // add stage: fraction of position plus offset, aligned to the output, zero for rows not below the horizon
   logic [FRAC_BITS-1:0] sum_x;
   logic [FRAC_BITS-1:0] sum_y;

   logic    a_valid_ff;
   rsp_type a_data_ff, a_data_in;

   always_comb begin
      sum_x = FRAC_BITS'(cfg.cam_pos_x[FRAC_BITS-1:0] + m_prod_x_ff[PROD_W-1:VEC_FRAC]);
      sum_y = FRAC_BITS'(cfg.cam_pos_y[FRAC_BITS-1:0] + m_prod_y_ff[PROD_W-1:VEC_FRAC]);
      if (m_floor_ff) begin
         a_data_in.tex_u = TEX_W'({sum_x, {TEX_W{1'b0}}} >> FRAC_BITS);
         a_data_in.tex_v = TEX_W'({sum_y, {TEX_W{1'b0}}} >> FRAC_BITS);
      end else begin
         a_data_in.tex_u = '0;
         a_data_in.tex_v = '0;
      end
      a_data_in.floor_row = m_floor_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_data_ff <= a_data_in;
      end
   end

   // hold the whole pipeline only when the last stage cannot drain
   assign advance   = !(a_valid_ff && fifo_full);
   assign req_stall = !advance;

   ftcg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   ftcg_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (a_valid_ff && advance),
      .push_data (a_data_ff),
      .full      (fifo_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_valid_ff)
      else $error("request transfer did not enter the pipeline");
   assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && fifo_full |=> a_valid_ff && $stable(a_data_ff))
      else $error("last stage changed while the result buffer was full");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.floor_row |-> rsp_data.tex_u == '0 && rsp_data.tex_v == '0)
      else $error("nonzero coordinate for a row above the horizon");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: floor texture coordinate generator testbench
// Sends screen pixels through the request channel under several camera and
// screen settings and idle patterns. A scoreboard works out the expected
// floor texture coordinates of every pixel transfer and checks each result
// transfer against the oldest one in order.
// ----------------------------------------------------------------------------
module tb_top;
   import ftcg_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_ITEMS  = 210;
   localparam int CFG_W        = $bits(cfg_type);

   class coord_scoreboard;
      cfg_type cfg;
      rsp_type pending_coords[$];
      int      mismatches;

      function new();
         cfg.cam_pos_x     = RST_CAM_POS_X;
         cfg.cam_pos_y     = RST_CAM_POS_Y;
         cfg.view_dir_x    = RST_VIEW_DIR_X;
         cfg.view_dir_y    = RST_VIEW_DIR_Y;
         cfg.cam_plane_x   = RST_CAM_PLANE_X;
         cfg.cam_plane_y   = RST_CAM_PLANE_Y;
         cfg.screen_height = RST_SCREEN_H;
         cfg.screen_width  = RST_SCREEN_W;
         mismatches        = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_CAM_POS_X:   cfg.cam_pos_x     = val[POS_W-1:0];
            CSR_CAM_POS_Y:   cfg.cam_pos_y     = val[POS_W-1:0];
            CSR_VIEW_DIR_X:  cfg.view_dir_x    = val[VEC_W-1:0];
            CSR_VIEW_DIR_Y:  cfg.view_dir_y    = val[VEC_W-1:0];
            CSR_CAM_PLANE_X: cfg.cam_plane_x   = val[VEC_W-1:0];
            CSR_CAM_PLANE_Y: cfg.cam_plane_y   = val[VEC_W-1:0];
            CSR_SCREEN_H:    cfg.screen_height = val[SCR_W-1:0];
            CSR_SCREEN_W:    cfg.screen_width  = val[SCR_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [TEX_W-1:0] axis_frac(input logic [POS_W-1:0] pos,
                                           input logic signed [VEC_W-1:0] dir,
                                           input logic signed [VEC_W-1:0] plane,
                                           input longint row_dist,
                                           input logic [COL_W-1:0] column,
                                           input int w);
         longint num, ray, offset, coord;
         num    = 2 * longint'(plane) * longint'(column);
         ray    = (longint'(dir) - longint'(plane)) + num / longint'(w);
         offset = (row_dist * ray) >>> VEC_FRAC;
         coord  = longint'(pos) + offset;
         return coord[FRAC_BITS-1 -: TEX_W];
      endfunction

      function rsp_type floor_coord(req_type pix);
         rsp_type exp_coord;
         int      h, w, half;
         longint  row_dist;
         exp_coord = '0;
         h = (cfg.screen_height > MAX_SCREEN) ? MAX_SCREEN : int'(cfg.screen_height);
         w = (cfg.screen_width > MAX_SCREEN) ? MAX_SCREEN : int'(cfg.screen_width);
         if (w == 0) begin
            w = 1;
         end
         half = h / 2;
         if (int'(pix.row) <= half) begin
            return exp_coord;
         end
         row_dist = (longint'(half) << FRAC_BITS) / longint'(int'(pix.row) - half);
         exp_coord.tex_u = axis_frac(cfg.cam_pos_x, cfg.view_dir_x, cfg.cam_plane_x,
                                     row_dist, pix.column, w);
         exp_coord.tex_v = axis_frac(cfg.cam_pos_y, cfg.view_dir_y, cfg.cam_plane_y,
                                     row_dist, pix.column, w);
         exp_coord.floor_row = 1'b1;
         return exp_coord;
      endfunction

      function void note_pixel(req_type pix);
         pending_coords.push_back(floor_coord(pix));
      endfunction

      function void compare_field(string fld, logic [TEX_W-1:0] exp_val,
                                  logic [TEX_W-1:0] got_val);
         if (exp_val !== got_val) begin
            mismatches++;
            if (mismatches <= 60) begin
               $display("%0t: %s mismatch, expected %h, actual %h",
                        $time, fld, exp_val, got_val);
            end
         end
      endfunction

      function void check_coord(rsp_type got);
         rsp_type exp_coord;
         if (pending_coords.size() == 0) begin
            mismatches++;
            if (mismatches <= 60) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end
            return;
         end
         exp_coord = pending_coords.pop_front();
         compare_field("tex_u", exp_coord.tex_u, got.tex_u);
         compare_field("tex_v", exp_coord.tex_v, got.tex_v);
         compare_field("floor_row", TEX_W'(exp_coord.floor_row), TEX_W'(got.floor_row));
      endfunction

      function int pending();
         return pending_coords.size();
      endfunction
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wr_en   = 1'b0;
   csr_index_type         csr_index   = CSR_CAM_POS_X;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   coord_scoreboard board = new();
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_asked    = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int cycle_count   = 0;

   floor_texture_coord_gen dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            board.note_pixel(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            board.check_coord(rsp_data);
         end
      end
   end

   // hold off the result channel for a long stretch on request, else stall at random
   always @(negedge clock) begin
      if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_pixel(input int r, input int c);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_data.row    <= ROW_W'(r);
      req_data.column <= COL_W'(c);
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      board.set_reg(idx, val);
   endtask

   task automatic set_camera(input cfg_type c);
      drain();
      write_csr(CSR_CAM_POS_X,   CSR_DATA_W'(c.cam_pos_x));
      write_csr(CSR_CAM_POS_Y,   CSR_DATA_W'(c.cam_pos_y));
      write_csr(CSR_VIEW_DIR_X,  CSR_DATA_W'(c.view_dir_x));
      write_csr(CSR_VIEW_DIR_Y,  CSR_DATA_W'(c.view_dir_y));
      write_csr(CSR_CAM_PLANE_X, CSR_DATA_W'(c.cam_plane_x));
      write_csr(CSR_CAM_PLANE_Y, CSR_DATA_W'(c.cam_plane_y));
      write_csr(CSR_SCREEN_H,    CSR_DATA_W'(c.screen_height));
      write_csr(CSR_SCREEN_W,    CSR_DATA_W'(c.screen_width));
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic cfg_type pick_camera(input int kind);
      cfg_type c;
      if (kind == 0) begin
         c.cam_pos_x     = POS_W'($urandom());
         c.cam_pos_y     = POS_W'($urandom());
         c.view_dir_x    = VEC_W'(int'($urandom_range(32768)) - 16384);
         c.view_dir_y    = VEC_W'(int'($urandom_range(32768)) - 16384);
         c.cam_plane_x   = VEC_W'(int'($urandom_range(32768)) - 16384);
         c.cam_plane_y   = VEC_W'(int'($urandom_range(32768)) - 16384);
         c.screen_height = SCR_W'(2 * $urandom_range(1024, 8));
         c.screen_width  = SCR_W'($urandom_range(MAX_SCREEN, 16));
      end else if (kind == 1) begin
         c = cfg_type'(CFG_W'({$urandom(), $urandom(), $urandom(), $urandom(),
                               $urandom()}));
      end else begin
         c.cam_pos_x     = $urandom_range(1) ? '1 : '0;
         c.cam_pos_y     = $urandom_range(1) ? '1 : '0;
         c.view_dir_x    = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         c.view_dir_y    = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         c.cam_plane_x   = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         c.cam_plane_y   = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         c.screen_height = $urandom_range(1) ? SCR_W'(16) : SCR_W'(MAX_SCREEN);
         c.screen_width  = $urandom_range(1) ? SCR_W'(16) : SCR_W'(MAX_SCREEN);
      end
      return c;
   endfunction

   task automatic send_random_pixel();
      int h, w, half, lo, hi, pick, r, c;
      h = (board.cfg.screen_height > MAX_SCREEN) ? MAX_SCREEN
                                                  : int'(board.cfg.screen_height);
      w = (board.cfg.screen_width > MAX_SCREEN) ? MAX_SCREEN : int'(board.cfg.screen_width);
      if (w == 0) begin
         w = 1;
      end
      half = h / 2;
      lo   = half + 1;
      hi   = 2047;
      pick = $urandom_range(99);
      if (pick < 10) begin
         r = $urandom_range(lo + 3, lo);
      end else if (pick < 85) begin
         if ((h - 1 >= lo) && ($urandom_range(99) < 70)) begin
            hi = h - 1;
         end
         r = $urandom_range(hi, lo);
      end else begin
         r = $urandom_range(half, 0);
      end
      c = ($urandom_range(99) < 90) ? int'($urandom_range(w - 1, 0))
                                    : int'($urandom_range(2047, 0));
      send_pixel(r, c);
   endtask

   initial begin
      cfg_type c;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset camera: horizon at row 240, width 640
      send_pixel(0, 0);
      send_pixel(239, 320);
      send_pixel(240, 639);
      send_pixel(241, 0);
      send_pixel(241, 639);
      send_pixel(479, 320);
      send_pixel(480, 640);
      send_pixel(2047, 2047);
      send_pixel(300, 1024);
      send_pixel(1000, 5);

      // oversized height, zero width, vector extremes
      c = '{cam_pos_x: '1, cam_pos_y: '0, view_dir_x: 16'sh8000, view_dir_y: 16'sh7fff,
            cam_plane_x: 16'sh7fff, cam_plane_y: 16'sh8000,
            screen_height: SCR_W'(4095), screen_width: SCR_W'(0)};
      set_camera(c);
      send_pixel(1024, 0);
      send_pixel(1025, 0);
      send_pixel(1025, 2047);
      send_pixel(2047, 1);

      // odd height, oversized width
      c = '{cam_pos_x: 24'h000001, cam_pos_y: 24'h80ffff, view_dir_x: 16'sh4000,
            view_dir_y: 16'sh8000, cam_plane_x: 16'sh8000, cam_plane_y: 16'sh2666,
            screen_height: SCR_W'(17), screen_width: SCR_W'(4095)};
      set_camera(c);
      send_pixel(8, 3);
      send_pixel(9, 2047);
      send_pixel(16, 100);
      send_pixel(17, 2047);

      // zero height puts the horizon at the top row
      c.screen_height = '0;
      c.screen_width  = SCR_W'(1);
      set_camera(c);
      send_pixel(0, 0);
      send_pixel(1, 1);
      send_pixel(2047, 0);

      for (int phase = 0; phase < 8; phase++) begin
         set_camera(pick_camera(phase % 3));
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 71; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 71; end
            default: begin send_idle_pct = 24; stall_pct = 24; end
         endcase
         if (phase == 4) begin
            hold_asked++;
         end
         repeat (PHASE_ITEMS) send_random_pixel();
      end

      drain();
      repeat (40) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
